>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// Both macros expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> rtl/core/wtrs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wtrs_pkg
// Types and constants for the waypoint table with radius search.
// ---------------------------------------------------------------------------
package wtrs_pkg;

  localparam int COORD_W = 16;
  localparam int RAD_W   = 16;
  localparam int PATH_W  = 8;
  localparam int SLOT_W  = 10;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int R2_W    = 2 * RAD_W;
  localparam int DIST_W  = SQ_W + 1;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_FIND   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_DELIVER = 3'b100
  } state_t;

  // Control into the distance pipeline.
  typedef struct packed {
    logic valid;
    logic flush;
  } dist_ctrl_t;

  // Status out of the distance pipeline.
  typedef struct packed {
    logic valid;
    logic hit;
    logic busy;
  } dist_stat_t;

endpackage

>>> rtl/core/wtrs_dist.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wtrs_dist
// Two-stage distance check: squared differences, then sum and compare
// against the squared radius.
// ---------------------------------------------------------------------------
module wtrs_dist #(
  parameter int IDX_W = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wtrs_pkg::dist_ctrl_t                  ctrl,
  input  logic [IDX_W-1:0]                      idx,
  input  logic signed [wtrs_pkg::COORD_W-1:0]   entry_x,
  input  logic signed [wtrs_pkg::COORD_W-1:0]   entry_y,
  input  logic signed [wtrs_pkg::COORD_W-1:0]   query_x,
  input  logic signed [wtrs_pkg::COORD_W-1:0]   query_y,
  input  logic [wtrs_pkg::R2_W-1:0]             r2,
  output wtrs_pkg::dist_stat_t                  stat,
  output logic [IDX_W-1:0]                      hit_idx
);
  import wtrs_pkg::*;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] prod_x;
  logic signed [2*COORD_W+1:0] prod_y;
  logic [DIST_W-1:0]           dist_sum;

  logic             sa_valid;
  logic [IDX_W-1:0] sa_idx;
  logic [SQ_W-1:0]  sq_x;
  logic [SQ_W-1:0]  sq_y;

  logic             sb_valid;
  logic             sb_hit;
  logic [IDX_W-1:0] sb_idx;

  always_comb begin
    dx       = {entry_x[COORD_W-1], entry_x} - {query_x[COORD_W-1], query_x};
    dy       = {entry_y[COORD_W-1], entry_y} - {query_y[COORD_W-1], query_y};
    prod_x   = dx * dx;
    prod_y   = dy * dy;
    dist_sum = {1'b0, sq_x} + {1'b0, sq_y};
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      sa_valid <= 1'b0;
      sb_valid <= 1'b0;
    end else begin
      sa_valid <= ctrl.valid;
      sb_valid <= sa_valid;
    end
  end

  // A squared 17-bit difference never exceeds 2^32 - 1, so the low bits suffice.
  always_ff @(posedge clk) begin
    sa_idx <= idx;
    sq_x   <= prod_x[SQ_W-1:0];
    sq_y   <= prod_y[SQ_W-1:0];
    sb_idx <= sa_idx;
    sb_hit <= dist_sum < {1'b0, r2};
  end

  assign stat.valid = sb_valid;
  assign stat.hit   = sb_hit;
  assign stat.busy  = sa_valid || sb_valid;
  assign hit_idx    = sb_idx;

endmodule

>>> rtl/core/waypoint_table_radius_search_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// waypoint_table_radius_search_top
// Table of point slots with create and find-within-radius commands.
// ---------------------------------------------------------------------------
// Usage:
// Command words enter on cmd_valid/cmd_stall, results leave on
// res_valid/res_stall; a word moves when valid is high and stall is low.
// Every command word yields exactly one result word.
// Slots are never released, so the claimed slots are always slots 1 to N,
// tracked by a fill count. A create on a table that is not full writes
// the table memory at the fill count; its result is offered when the
// output register is free. A find reads the table memory one entry per
// cycle through a two-stage distance pipeline; the first hit ends the
// scan, a miss is reported once the scan has passed all claimed slots,
// and either result is offered when the output register is free. The
// single read port of the table memory sets the scan rate.
// One command is worked on at a time; cmd_stall is low while the block is
// idle, so the next word is taken while a result still waits in the output
// register. If the receiver stalls, the finished result is held until the
// output register is free.
// Reset empties the table at once by clearing the fill count.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module waypoint_table_radius_search_top #(
  parameter int SLOTS = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  logic                                 command,
  input  logic signed [wtrs_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [wtrs_pkg::COORD_W-1:0]  pos_y,
  input  logic [wtrs_pkg::RAD_W-1:0]           radius,
  input  logic [wtrs_pkg::SLOT_W-1:0]          exclude_slot,
  input  logic [wtrs_pkg::PATH_W-1:0]          path_number,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [wtrs_pkg::SLOT_W-1:0]          slot,
  output logic                                 success
);
  import wtrs_pkg::*;

  localparam int AW     = $clog2(SLOTS);
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int CMPW   = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int WORD_W = 2 * COORD_W + PATH_W;

  state_t state;
  state_t state_next;

  logic [CW-1:0] fill_count;
  logic [CW-1:0] rd_idx;

  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;
  logic [R2_W-1:0]           r2;
  logic [SLOT_W-1:0]         excl;
  logic [CW-1:0]             found_slot;
  logic                      found_ok;

  logic [WORD_W-1:0] mem [SLOTS];
  logic [WORD_W-1:0] mem_q;
  logic              v1;
  logic [CW-1:0]     idx1;

  logic       accept;
  logic       table_full;
  logic       rd_en;
  logic       hit_now;
  logic       scan_end;
  logic       out_free;
  logic       excl_hit;
  logic [R2_W-1:0] r2_calc;

  dist_ctrl_t    ctrl;
  dist_stat_t    stat;
  logic [CW-1:0] hit_idx;

  always_comb begin
    accept     = cmd_valid && !cmd_stall;
    table_full = fill_count == CW'(SLOTS);
    hit_now    = (state == ST_SCAN) && stat.valid && stat.hit;
    rd_en      = (state == ST_SCAN) && (rd_idx < fill_count) && !hit_now;
    scan_end   = (state == ST_SCAN) && (rd_idx == fill_count) && !v1 && !stat.busy;
    out_free   = !res_valid || !res_stall;
    excl_hit   = (CMPW'(idx1) + CMPW'(1)) == CMPW'(excl);
    r2_calc    = R2_W'(radius) * R2_W'(radius);
    ctrl.valid = v1 && !excl_hit;
    ctrl.flush = hit_now;
  end

  assign cmd_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (command == CMD_FIND) ? ST_SCAN : ST_DELIVER;
        end
      end
      ST_SCAN: begin
        if (hit_now || scan_end) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      rd_idx     <= '0;
      v1         <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= rd_en;
      if (accept && command == CMD_CREATE && !table_full) begin
        fill_count <= fill_count + CW'(1);
      end
      if (accept) begin
        rd_idx <= '0;
      end else if (rd_en) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (state == ST_DELIVER && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query_x <= pos_x;
      query_y <= pos_y;
      excl    <= exclude_slot;
      r2      <= r2_calc;
      if (command == CMD_CREATE && !table_full) begin
        found_slot <= fill_count + CW'(1);
        found_ok   <= 1'b1;
      end else begin
        found_slot <= '0;
        found_ok   <= 1'b0;
      end
    end else if (hit_now) begin
      found_slot <= hit_idx + CW'(1);
      found_ok   <= 1'b1;
    end
    if (state == ST_DELIVER && out_free) begin
      slot    <= SLOT_W'(found_slot);
      success <= found_ok;
    end
  end

  // Table memory: one write port for create, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (accept && command == CMD_CREATE && !table_full) begin
      mem[fill_count[AW-1:0]] <= {pos_x, pos_y, path_number};
    end
    if (rd_en) begin
      mem_q <= mem[rd_idx[AW-1:0]];
      idx1  <= rd_idx;
    end
  end

  wtrs_dist #(
    .IDX_W (CW)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .idx     (idx1),
    .entry_x (mem_q[WORD_W-1 -: COORD_W]),
    .entry_y (mem_q[WORD_W-COORD_W-1 -: COORD_W]),
    .query_x (query_x),
    .query_y (query_y),
    .r2      (r2),
    .stat    (stat),
    .hit_idx (hit_idx)
  );

  `ASSERT_NEVER(a_fill_range, clk, rst, fill_count > CW'(SLOTS), "fill count beyond table size")
  `ASSERT_PROP(a_res_from_deliver, clk, rst, $rose(res_valid) |-> $past(state == ST_DELIVER), "result raised outside delivery")
  `ASSERT_PROP(a_stat_in_scan, clk, rst, stat.valid |-> state == ST_SCAN, "distance result outside a scan")
  `ASSERT_PROP(a_ok_has_slot, clk, rst, (state == ST_DELIVER && found_ok) |-> found_slot != '0, "success without a slot")

endmodule
